/* hdl/wheel_tick_speed_estimator_assert.svh */
// ----------------------------------------------------------------------------
// Wheel tick speed estimator assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef WHEEL_TICK_SPEED_ESTIMATOR_ASSERT_SVH
`define WHEEL_TICK_SPEED_ESTIMATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define WTSE_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define WTSE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/wtse_pkg.sv */
// ----------------------------------------------------------------------------
// Wheel tick speed estimator package
// Field widths, register indexes, reset values and sequencer types.
// ----------------------------------------------------------------------------
package wtse_pkg;

   // Field widths
   localparam int SPEED_BITS = 26;
   localparam int CIRC_BITS  = 16;
   localparam int MIN_BITS   = 16;
   localparam int MAX_BITS   = 15;
   localparam int CSR_BITS   = 16;
   localparam int IDX_BITS   = 2;
   localparam int SCALE_BITS = 10;
   localparam int PROD_BITS  = SPEED_BITS + MAX_BITS;

   // Divider step count
   localparam int CNT_BITS = $clog2(SPEED_BITS);
   localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(SPEED_BITS - 1);

   // mm/s per mm/ms
   localparam logic [SCALE_BITS-1:0] SCALE_FACTOR = SCALE_BITS'(1000);

   // Commands
   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   // Register indexes
   localparam logic [IDX_BITS-1:0] CSR_CIRC    = 2'd0;
   localparam logic [IDX_BITS-1:0] CSR_MIN_INT = 2'd1;
   localparam logic [IDX_BITS-1:0] CSR_MAX_INT = 2'd2;

   // Register reset values
   localparam logic [CIRC_BITS-1:0] CIRC_RESET    = 16'd1500;
   localparam logic [MIN_BITS-1:0]  MIN_INT_RESET = 16'd20;
   localparam logic [MAX_BITS-1:0]  MAX_INT_RESET = 15'd2000;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIV,
      ST_RESULT,
      ST_CLAMP,
      ST_OUT
   } state_type;

   // Outcome of the update decision
   typedef enum logic [2:0] {
      DEC_ZERO,
      DEC_FIRST,
      DEC_TIMEOUT,
      DEC_EXTRAP,
      DEC_HOLD,
      DEC_NEW
   } decide_type;

   // What the divider quotient is used for
   typedef enum logic [1:0] {
      MODE_FIRST,
      MODE_NEW,
      MODE_EXTRAP
   } mode_type;

endpackage

/* hdl/wheel_tick_speed_estimator.sv */
// ----------------------------------------------------------------------------
// Wheel tick speed estimator
// Debounces wheel ticks, keeps the last two tick times and on each update
// word reports circumference*1000/period, with timeout and linear decay.
// ----------------------------------------------------------------------------
//
//  channel | ports                                 | direction
//  --------+---------------------------------------+----------
//  req     | req_valid req_stall req_command       | in
//          | req_now_ms                            |
//  rsp     | rsp_valid rsp_stall rsp_speed_mm_per_s| out
//  csr     | csr_write_en csr_index csr_wdata      | in
//
//  A tick word gives no rsp word.
//  An update word passes decide and out, with div and result between them for
//  a division; the 26-step restoring divider serves both period and slope.
//  req is stalled from acceptance of an update until its rsp word is loaded.
//  The rsp register holds its word under stall; the sequencer waits on it.
//  Synchronous active-high reset restores register defaults, clears history.
// ----------------------------------------------------------------------------
`include "wheel_tick_speed_estimator_assert.svh"

module wheel_tick_speed_estimator #(
   parameter int TIME_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // request words
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [31:0]                     req_now_ms,
   // response words
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [wtse_pkg::SPEED_BITS-1:0] rsp_speed_mm_per_s,
   // register writes
   input  logic                            csr_write_en,
   input  logic [wtse_pkg::IDX_BITS-1:0]   csr_index,
   input  logic [wtse_pkg::CSR_BITS-1:0]   csr_wdata
);

   localparam int SB = wtse_pkg::SPEED_BITS;
   localparam int PB = wtse_pkg::PROD_BITS;

   // Configuration
   logic [wtse_pkg::CIRC_BITS-1:0] circ_ff;
   logic [wtse_pkg::MIN_BITS-1:0]  min_int_ff;
   logic [wtse_pkg::MAX_BITS-1:0]  max_int_ff;

   // History and speed state
   logic [TIME_BITS-1:0] newest_ff, older_ff, used_newest_ff, used_older_ff;
   logic [SB-1:0]        current_speed_ff, previous_speed_ff;

   // Sequencer
   wtse_pkg::state_type state_ff, state_in;
   wtse_pkg::mode_type  mode_ff;
   logic [TIME_BITS-1:0] now_ff;

   // Shared divider
   logic [SB-1:0]                 dvd_ff;
   logic [TIME_BITS-1:0]          dvs_ff, rem_ff;
   logic [wtse_pkg::CNT_BITS-1:0] step_cnt_ff;
   logic [TIME_BITS:0]            rem_shift;
   logic                          rem_geq;
   logic [TIME_BITS-1:0]          rem_next;

   // Extrapolation
   logic [wtse_pkg::MAX_BITS-1:0] elapsed_ff;
   logic [PB-1:0]                 prod_ff;
   logic [SB-1:0]                 clamp_speed;

   // Output register
   logic          rsp_valid_ff;
   logic [SB-1:0] rsp_speed_ff;

   // Control
   logic req_accept, tick_take, div_step, out_load;

   // Decision datapath
   wtse_pkg::decide_type dec;
   logic [TIME_BITS-1:0] tick_gap, period, period_nz, since, span;
   logic [SB-1:0]        scaled;
   logic                 dec_clear;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_speed_mm_per_s = rsp_speed_ff;

   // --------------------------------------------------------------------
   // Combinational datapath
   // --------------------------------------------------------------------

   // Tick debounce on the incoming word
   always_comb begin
      tick_gap  = req_now_ms[TIME_BITS-1:0] - newest_ff;
      tick_take = req_accept && (req_command == wtse_pkg::CMD_TICK)
                  && (tick_gap > TIME_BITS'(min_int_ff));
   end

   // Period, elapsed time, span and the scaled circumference
   always_comb begin
      period    = newest_ff - older_ff;
      period_nz = (period == '0) ? TIME_BITS'(1) : period;
      since     = now_ff - used_newest_ff;
      span      = used_newest_ff - used_older_ff;
      scaled    = SB'(SB'(circ_ff) * SB'(wtse_pkg::SCALE_FACTOR));
      dec_clear = since > TIME_BITS'({1'b0, max_int_ff} << 1);
   end

   // Update decision
   always_comb begin
      priority if (older_ff == '0) begin
         dec = wtse_pkg::DEC_ZERO;
      end else if (used_newest_ff == '0) begin
         dec = wtse_pkg::DEC_FIRST;
      end else if (used_older_ff == older_ff) begin
         priority if (since > TIME_BITS'(max_int_ff)) begin
            dec = wtse_pkg::DEC_TIMEOUT;
         end else if ((previous_speed_ff > current_speed_ff) && (span != '0)) begin
            dec = wtse_pkg::DEC_EXTRAP;
         end else begin
            dec = wtse_pkg::DEC_HOLD;
         end
      end else begin
         dec = wtse_pkg::DEC_NEW;
      end
   end

   // One restoring division step
   always_comb begin
      rem_shift = {rem_ff, dvd_ff[SB-1]};
      rem_geq   = rem_shift >= {1'b0, dvs_ff};
      rem_next  = rem_geq ? TIME_BITS'(rem_shift - {1'b0, dvs_ff})
                          : rem_shift[TIME_BITS-1:0];
   end

   // Speed minus slope*elapsed, floored at zero
   always_comb begin
      clamp_speed = (prod_ff > PB'(current_speed_ff))
                    ? '0 : SB'(current_speed_ff - prod_ff[SB-1:0]);
   end

   // --------------------------------------------------------------------
   // Sequencer
   // --------------------------------------------------------------------

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wtse_pkg::ST_IDLE: begin
            if (req_accept && (req_command == wtse_pkg::CMD_UPDATE)) begin
               state_in = wtse_pkg::ST_DECIDE;
            end
         end
         wtse_pkg::ST_DECIDE: begin
            if ((dec == wtse_pkg::DEC_FIRST) || (dec == wtse_pkg::DEC_EXTRAP)
                || (dec == wtse_pkg::DEC_NEW)) begin
               state_in = wtse_pkg::ST_DIV;
            end else begin
               state_in = wtse_pkg::ST_OUT;
            end
         end
         wtse_pkg::ST_DIV: begin
            if (step_cnt_ff == wtse_pkg::DIV_LAST) begin
               state_in = wtse_pkg::ST_RESULT;
            end
         end
         wtse_pkg::ST_RESULT: begin
            state_in = (mode_ff == wtse_pkg::MODE_EXTRAP) ? wtse_pkg::ST_CLAMP
                                                          : wtse_pkg::ST_OUT;
         end
         wtse_pkg::ST_CLAMP: begin
            state_in = wtse_pkg::ST_OUT;
         end
         wtse_pkg::ST_OUT: begin
            if (out_load) begin
               state_in = wtse_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wtse_pkg::ST_IDLE;
         end
      endcase
   end

   // Control outputs
   always_comb begin
      req_stall  = (state_ff != wtse_pkg::ST_IDLE);
      req_accept = req_valid && !req_stall;
      div_step   = (state_ff == wtse_pkg::ST_DIV);
      out_load   = (state_ff == wtse_pkg::ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wtse_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // --------------------------------------------------------------------
   // Configuration registers
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         circ_ff    <= wtse_pkg::CIRC_RESET;
         min_int_ff <= wtse_pkg::MIN_INT_RESET;
         max_int_ff <= wtse_pkg::MAX_INT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            wtse_pkg::CSR_CIRC:    circ_ff    <= csr_wdata;
            wtse_pkg::CSR_MIN_INT: min_int_ff <= csr_wdata;
            wtse_pkg::CSR_MAX_INT: max_int_ff <= csr_wdata[wtse_pkg::MAX_BITS-1:0];
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------------------
   // History and speed state
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff         <= '0;
         older_ff          <= '0;
         used_newest_ff    <= '0;
         used_older_ff     <= '0;
         current_speed_ff  <= '0;
         previous_speed_ff <= '0;
         mode_ff           <= wtse_pkg::MODE_NEW;
      end else begin
         // accepted tick shifts the pair
         if (tick_take) begin
            older_ff  <= newest_ff;
            newest_ff <= req_now_ms[TIME_BITS-1:0];
         end

         if (state_ff == wtse_pkg::ST_DECIDE) begin
            unique case (dec)
               wtse_pkg::DEC_ZERO: begin
                  current_speed_ff <= '0;
               end
               wtse_pkg::DEC_FIRST: begin
                  used_older_ff  <= older_ff;
                  used_newest_ff <= newest_ff;
                  mode_ff        <= wtse_pkg::MODE_FIRST;
               end
               wtse_pkg::DEC_TIMEOUT: begin
                  current_speed_ff <= '0;
                  if (dec_clear) begin
                     previous_speed_ff <= '0;
                     older_ff          <= '0;
                  end
               end
               wtse_pkg::DEC_EXTRAP: begin
                  mode_ff <= wtse_pkg::MODE_EXTRAP;
               end
               wtse_pkg::DEC_HOLD: ;
               wtse_pkg::DEC_NEW: begin
                  used_older_ff     <= used_newest_ff;
                  used_newest_ff    <= newest_ff;
                  previous_speed_ff <= current_speed_ff;
                  mode_ff           <= wtse_pkg::MODE_NEW;
               end
               default: ;
            endcase
         end

         // quotient is a period speed unless extrapolating
         if ((state_ff == wtse_pkg::ST_RESULT) && (mode_ff != wtse_pkg::MODE_EXTRAP)) begin
            current_speed_ff <= dvd_ff;
            if (mode_ff == wtse_pkg::MODE_FIRST) begin
               previous_speed_ff <= dvd_ff;
            end
         end

         if (state_ff == wtse_pkg::ST_CLAMP) begin
            current_speed_ff <= clamp_speed;
         end
      end
   end

   // --------------------------------------------------------------------
   // Divider, multiplier and sample registers (no reset needed)
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         now_ff <= req_now_ms[TIME_BITS-1:0];
      end

      // load operands for period or slope
      if (state_ff == wtse_pkg::ST_DECIDE) begin
         rem_ff      <= '0;
         step_cnt_ff <= '0;
         elapsed_ff  <= since[wtse_pkg::MAX_BITS-1:0];
         if (dec == wtse_pkg::DEC_EXTRAP) begin
            dvd_ff <= previous_speed_ff - current_speed_ff;
            dvs_ff <= span;
         end else begin
            dvd_ff <= scaled;
            dvs_ff <= period_nz;
         end
      end

      // one quotient bit per cycle
      if (div_step) begin
         rem_ff      <= rem_next;
         dvd_ff      <= {dvd_ff[SB-2:0], rem_geq};
         step_cnt_ff <= step_cnt_ff + 1'b1;
      end

      // slope magnitude times elapsed time
      if (state_ff == wtse_pkg::ST_RESULT) begin
         prod_ff <= PB'(dvd_ff) * PB'(elapsed_ff);
      end
   end

   // --------------------------------------------------------------------
   // Response register
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_speed_ff <= current_speed_ff;
      end
   end

   // --------------------------------------------------------------------
   // Assertions
   // --------------------------------------------------------------------
   `WTSE_ASSERT_NEXT(a_update_decides, clock, reset,
      req_accept && (req_command == wtse_pkg::CMD_UPDATE),
      state_ff == wtse_pkg::ST_DECIDE, "update word did not reach decide")
   `WTSE_ASSERT_IMPL(a_div_count, clock, reset,
      state_ff == wtse_pkg::ST_DIV, step_cnt_ff <= wtse_pkg::DIV_LAST,
      "divider step count overran")
   `WTSE_ASSERT_NEXT(a_no_pair_zero, clock, reset,
      (state_ff == wtse_pkg::ST_DECIDE) && (older_ff == '0),
      current_speed_ff == '0, "speed not zero without a tick pair")
   `WTSE_ASSERT_NEXT(a_decay_only, clock, reset,
      state_ff == wtse_pkg::ST_CLAMP,
      current_speed_ff <= $past(current_speed_ff), "extrapolation raised speed")
   `WTSE_ASSERT_NEXT(a_rsp_load, clock, reset, out_load,
      rsp_valid_ff && (rsp_speed_ff == $past(current_speed_ff)),
      "response word not loaded from current speed")

endmodule
